// ===== sv/dfa_pkg.sv =====
// Shared constants and types for the table driven DFA runner.
package dfa_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 256;

    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;
    localparam int KIND_W  = 2;

    localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // entry: valid bit above the target state
    localparam int ENTRY_W     = STATE_W + 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = STATE_W;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FEED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_START  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT = 1'd1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_FINISH = 4'b1000
    } dfa_state_t;

endpackage

// ===== sv/table_driven_dfa_runner.sv =====
// Top level: loadable DFA with its transition table in a synchronous RAM.
// Load transactions leave the runner idle; a feed passes through S_LOOKUP, where the table
// RAM's registered read of the present state's entry arrives, and a finish through S_FINISH.
// S_LOOKUP and S_FINISH register a result once the output is free; it then waits for m_axis_tready.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes all TABLE_DEPTH
// (16384) table entries while s_axis_tready stays low.
module table_driven_dfa_runner
    import dfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // from_state[5:0], symbol[13:6], to_state[19:14], zero pad[23:20]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // current_state[5:0], bad_symbol[6], accepted[7]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // verdict_valid[0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    function automatic logic [ADDR_W-1:0] table_addr(input logic [STATE_W-1:0] st,
                                                     input logic [SYM_W-1:0]   sym);
        table_addr = ADDR_W'(ADDR_W'(st) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(sym));
    endfunction

    dfa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [STATE_W-1:0]    start_reg, start_next;
    logic [STATE_W-1:0]    accept_reg, accept_next;
    logic [STATE_W-1:0]    present_reg, present_next;
    logic                  error_reg, error_next;
    logic                  in_range_reg, in_range_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_user_reg, out_user_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [STATE_W-1:0]    in_from;
    logic [SYM_W-1:0]      in_sym;
    logic [STATE_W-1:0]    in_to;
    logic                  in_fire;
    logic                  out_free;
    logic                  hit;

    assign in_from = s_axis_tdata[STATE_W-1:0];
    assign in_sym  = s_axis_tdata[STATE_W+SYM_W-1:STATE_W];
    assign in_to   = s_axis_tdata[2*STATE_W+SYM_W-1:STATE_W+SYM_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign hit           = in_range_reg && ram_rdata[ENTRY_W-1];

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        start_next     = start_reg;
        accept_next    = accept_reg;
        present_next   = present_reg;
        error_next     = error_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = table_addr(in_from, in_sym);
        ram_wdata      = {1'b1, in_to};
        ram_re         = 1'b0;
        ram_raddr      = table_addr(present_reg, in_sym);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        KIND_LOAD:
                        begin
                            ram_we = (int'(in_from) < NUM_STATES) &&
                                     (int'(in_sym) < NUM_SYMBOLS) &&
                                     (int'(in_to) < NUM_STATES);
                        end
                        KIND_FEED:
                        begin
                            // a feed after an error is dropped without a result
                            if (!error_reg)
                            begin
                                ram_re        = 1'b1;
                                in_range_next = (int'(present_reg) < NUM_STATES) &&
                                                (int'(in_sym) < NUM_SYMBOLS);
                                state_next    = S_LOOKUP;
                            end
                        end
                        KIND_FINISH:
                        begin
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = 1'b0;
                    if (hit)
                    begin
                        present_next  = ram_rdata[STATE_W-1:0];
                        out_data_next = {1'b0, 1'b0, ram_rdata[STATE_W-1:0]};
                    end
                    else
                    begin
                        error_next    = 1'b1;
                        out_data_next = {1'b0, 1'b1, present_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = 1'b1;
                    out_data_next  = {!error_reg && (present_reg == accept_reg),
                                      error_reg, present_reg};
                    present_next   = start_reg;
                    error_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the user must write only while idle so writes never race the sequence logic; the block does not enforce it
        if (cfg_wr_en)
        begin
            if (cfg_addr == REG_START)
            begin
                start_next   = cfg_wdata;
                present_next = cfg_wdata;
                error_next   = 1'b0;
            end
            else if (cfg_addr == REG_ACCEPT)
            begin
                accept_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= '0;
            accept_reg    <= '0;
            present_reg   <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            start_reg     <= start_next;
            accept_reg    <= accept_next;
            present_reg   <= present_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    dfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== sv/dfa_ram.sv =====
// Generic simple dual port RAM with registered read data.
module dfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dfa_checker.sv =====
// Port level checks for the DFA runner, bound to the top level.
module dfa_checker
    import dfa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [KIND_W-1:0]     s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  cfg_wr_en,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // an errored sequence never reports accept
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[STATE_W] |-> !m_axis_tdata[STATE_W+1])
        else $error("accept reported with error");

    // path steps carry no verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[STATE_W+1])
        else $error("accept on a path step");

    // a finish holds off input for its verdict cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_FINISH) |=>
            !s_axis_tready)
        else $error("input taken during finish");

endmodule

bind table_driven_dfa_runner dfa_checker u_dfa_checker (.*);

// ===== tb/table_driven_dfa_runner_test.sv =====
// Self-checking testbench for the table driven DFA runner: directed rows, then random phases.
`timescale 1ns / 1ps

module table_driven_dfa_runner_test
    import dfa_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int ITEM_TARGET    = 1050;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NUM_ROWS       = 23;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               bad;
        logic               verdict;
        logic               acc;
    } path_step_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] from_st;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] to_st;
        logic               fixed;
        logic               emits;
        path_step_t         res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = KIND_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_START;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    bit                 hit_tbl  [TABLE_DEPTH];
    logic [STATE_W-1:0] next_tbl [TABLE_DEPTH];
    logic [STATE_W-1:0] seq_start  = '0;
    logic [STATE_W-1:0] seq_accept = '0;
    logic [STATE_W-1:0] seq_state  = '0;
    bit                 seq_err    = 1'b0;

    path_step_t pending_steps [$];

    // typed expectation that rides along with the item on the bus
    bit         row_fixed = 1'b0;
    bit         row_emits = 1'b0;
    path_step_t row_res   = '0;

    int errors        = 0;
    int quiet_cycles  = 0;
    int items_counted = 0;
    int burst_left    = 0;
    int gap_max       = 3;
    int rx_cycle      = 0;

    // state, bad, verdict, accepted
    stim_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{KIND_FINISH, 6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd0,  1'b0, 1'b1, 1'b1}},
        '{KIND_FEED,   6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd0,  1'b1, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'h5A, 6'd0,  1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FINISH, 6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd0,  1'b1, 1'b1, 1'b0}},
        '{KIND_UNUSED, 6'd63, 8'hFF, 6'd63, 1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_LOAD,   6'd0,  8'h00, 6'd63, 1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_LOAD,   6'd63, 8'hFF, 6'd0,  1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_LOAD,   6'd0,  8'hFF, 6'd63, 1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_LOAD,   6'd0,  8'hFF, 6'd1,  1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd63, 1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'hFF, 6'd0,  1'b1, 1'b1, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'hFF, 6'd0,  1'b1, 1'b1, {6'd1,  1'b0, 1'b0, 1'b0}},
        '{KIND_FINISH, 6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd1,  1'b0, 1'b1, 1'b0}},
        '{KIND_LOAD,   6'd1,  8'hA5, 6'd42, 1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_LOAD,   6'd42, 8'h3C, 6'd0,  1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd21, 8'hFF, 6'd42, 1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'hA5, 6'd0,  1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'h3C, 6'd0,  1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FINISH, 6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd0,  1'b0, 1'b1, 1'b1}},
        '{KIND_FEED,   6'd0,  8'h00, 6'd0,  1'b0, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}},
        '{KIND_FEED,   6'd0,  8'h01, 6'd0,  1'b1, 1'b1, {6'd63, 1'b1, 1'b0, 1'b0}},
        '{KIND_FINISH, 6'd0,  8'h00, 6'd0,  1'b1, 1'b1, {6'd63, 1'b1, 1'b1, 1'b0}},
        '{KIND_UNUSED, 6'd21, 8'hC3, 6'd42, 1'b1, 1'b0, {6'd0,  1'b0, 1'b0, 1'b0}}
    };

    table_driven_dfa_runner DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the predicted automaton by one item; returns 1 when a result is due.
    function automatic bit dfa_step(input logic [KIND_W-1:0] kind,
                                    input logic [STATE_W-1:0] from_st,
                                    input logic [SYM_W-1:0] sym,
                                    input logic [STATE_W-1:0] to_st,
                                    output path_step_t step);
        logic [ADDR_W-1:0] addr;
        bit                hit;
        step = '0;
        case (kind)
            KIND_LOAD:
            begin
                addr = {from_st, sym};
                hit_tbl[addr] = 1'b1;
                next_tbl[addr] = to_st;
                return 1'b0;
            end
            KIND_FEED:
            begin
                // a sticky error swallows symbols until the next finish or start-state write
                if (seq_err)
                    return 1'b0;
                addr = {seq_state, sym};
                hit = hit_tbl[addr];
                if (hit)
                    seq_state = next_tbl[addr];
                else
                    seq_err = 1'b1;
                step.state = seq_state;
                step.bad = !hit;
                return 1'b1;
            end
            KIND_FINISH:
            begin
                step.state = seq_state;
                step.bad = seq_err;
                step.verdict = 1'b1;
                step.acc = !seq_err && (seq_state == seq_accept);
                seq_state = seq_start;
                seq_err = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void cfg_apply(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [CFG_DATA_W-1:0] data);
        if (addr == REG_START)
        begin
            // new start state also restarts the sequence in flight
            seq_start = data;
            seq_state = data;
            seq_err = 1'b0;
        end
        else if (addr == REG_ACCEPT)
            seq_accept = data;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("tb: %s (got %0d, expected %0d) at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin : monitor
        path_step_t step;
        path_step_t got;
        path_step_t want;
        bit         emits;
        if (rst_n)
        begin
            if (cfg_wr_en)
                cfg_apply(cfg_addr, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                emits = dfa_step(s_axis_tuser, s_axis_tdata[STATE_W-1:0],
                                 s_axis_tdata[STATE_W+SYM_W-1:STATE_W],
                                 s_axis_tdata[2*STATE_W+SYM_W-1:STATE_W+SYM_W], step);
                if (row_fixed)
                begin
                    if (row_emits)
                        pending_steps.insert(pending_steps.size(), row_res);
                end
                else if (emits)
                    pending_steps.insert(pending_steps.size(), step);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[STATE_W-1:0], m_axis_tdata[6], m_axis_tuser, m_axis_tdata[7]};
                if (pending_steps.size() == 0)
                    report("result with nothing pending", got, 0);
                else
                begin
                    want = pending_steps.pop_front();
                    if (got.state !== want.state)
                        report("current_state", got.state, want.state);
                    if (got.bad !== want.bad)
                        report("bad_symbol", got.bad, want.bad);
                    if (got.verdict !== want.verdict)
                        report("verdict_valid", got.verdict, want.verdict);
                    if (got.acc !== want.acc)
                        report("accepted", got.acc, want.acc);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        else
            quiet_cycles++;
    end

    // receiver: cycles through always-ready, light, heavy and long stalls
    always @(negedge clk)
    begin
        rx_cycle++;
        case ((rx_cycle / 256) % 4)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = ($urandom_range(0, 3) != 0);
            2: m_axis_tready = 1'($urandom_range(0, 1));
            default: m_axis_tready = ((rx_cycle % 16) < 4);
        endcase
    end

    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [STATE_W-1:0] from_st,
                             input logic [SYM_W-1:0] sym,
                             input logic [STATE_W-1:0] to_st,
                             input bit fixed, input bit emits, input path_step_t res);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, gap_max))
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        items_counted++;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = {{(IN_DATA_W-2*STATE_W-SYM_W){1'b0}}, to_st, sym, from_st};
        row_fixed = fixed;
        row_emits = emits;
        row_res = res;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // One phase: new settings, a small automaton loaded, then mostly well-formed sequences.
    task automatic run_phase(input int p);
        logic [STATE_W-1:0] states [8];
        logic [SYM_W-1:0]   syms [5];
        logic [STATE_W-1:0] new_start;
        logic [STATE_W-1:0] new_acc;
        int                 ns;
        int                 ny;
        int                 r;
        int                 quota_end;
        case (p)
            0: begin new_start = 6'd0;  new_acc = 6'd63; end
            1: begin new_start = 6'd63; new_acc = 6'd0;  end
            2: begin new_start = 6'd63; new_acc = 6'd63; end
            4: begin new_start = 6'd0;  new_acc = 6'd0;  end
            default:
            begin
                new_start = STATE_W'($urandom);
                new_acc = STATE_W'($urandom);
            end
        endcase
        // some phases change only the accept state, keeping the open sequence
        if (p % 4 != 3)
            cfg_write(REG_START, new_start);
        cfg_write(REG_ACCEPT, new_acc);
        gap_max = (p % 4 == 1) ? 0 : $urandom_range(1, 8);

        ns = $urandom_range(3, 8);
        ny = $urandom_range(2, 5);
        states[0] = seq_start;
        states[1] = seq_accept;
        for (int i = 2; i < ns; i++)
            states[i] = STATE_W'($urandom);
        for (int j = 0; j < ny; j++)
            syms[j] = SYM_W'($urandom);
        for (int i = 0; i < ns; i++)
            for (int j = 0; j < ny; j++)
                if ($urandom_range(0, 9) != 0)
                    send_item(KIND_LOAD, states[i], syms[j], states[$urandom_range(0, ns-1)],
                              1'b0, 1'b0, '0);
        repeat (2)
            send_item(KIND_LOAD, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                      1'b0, 1'b0, '0);

        quota_end = items_counted + 70;
        while (items_counted < quota_end)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(KIND_FEED, STATE_W'($urandom), syms[$urandom_range(0, ny-1)],
                          STATE_W'($urandom), 1'b0, 1'b0, '0);
            else if (r < 78)
                send_item(KIND_FEED, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                          1'b0, 1'b0, '0);
            else if (r < 90)
                send_item(KIND_FINISH, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                          1'b0, 1'b0, '0);
            else if (r < 95)
                send_item(KIND_LOAD, states[$urandom_range(0, ns-1)], syms[$urandom_range(0, ny-1)],
                          states[$urandom_range(0, ns-1)], 1'b0, 1'b0, '0);
            else
                send_item(KIND_UNUSED, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
                          1'b0, 1'b0, '0);
        end
    endtask

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : main
        int p;
        p = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first transaction waits out the table clearing pass
        for (int i = 0; i < NUM_ROWS; i++)
            send_item(directed_rows[i].kind, directed_rows[i].from_st, directed_rows[i].sym,
                      directed_rows[i].to_st, directed_rows[i].fixed, directed_rows[i].emits,
                      directed_rows[i].res);

        while (items_counted < ITEM_TARGET)
        begin
            wait_drained();
            run_phase(p);
            p++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_steps.size() != 0)
            report("results never delivered", pending_steps.size(), 0);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dfa_pkg.sv
sv/dfa_ram.sv
sv/table_driven_dfa_runner.sv
sv/dfa_checker.sv
tb/table_driven_dfa_runner_test.sv
